// ----- hw/rtl/mpsp_pkg.sv -----
// shared types and constants for the mesh packet stream parser
`default_nettype none

package mpsp_pkg;

    // byte position counter width and its saturation value
    localparam int POS_W = 17;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // fixed layout offsets
    localparam logic [POS_W-1:0] POS_VERSION  = 17'd0;
    localparam logic [POS_W-1:0] POS_TYPE     = 17'd1;
    localparam logic [POS_W-1:0] POS_TTL      = 17'd2;
    localparam logic [POS_W-1:0] POS_TS_FIRST = 17'd3;
    localparam logic [POS_W-1:0] POS_TS_LAST  = 17'd10;
    localparam logic [POS_W-1:0] POS_FLAGS    = 17'd11;
    localparam logic [POS_W-1:0] POS_LEN_LAST = 17'd13;
    localparam logic [POS_W-1:0] FIXED_PART   = 17'd14;
    localparam logic [POS_W-1:0] ID_BYTES     = 17'd8;

    // header lengths without and with the recipient id
    localparam logic [POS_W-1:0] HDR_LEN_SHORT = FIXED_PART + ID_BYTES;
    localparam logic [POS_W-1:0] HDR_LEN_LONG  = FIXED_PART + ID_BYTES + ID_BYTES;

    // flags byte bit that marks a recipient id
    localparam int FLAG_RECIPIENT_BIT = 0;

    // status codes
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_TOO_SHORT = 1'b1;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_STATUS  = 2'd2
    } record_kind_t;

    // one result record
    typedef struct packed {
        record_kind_t kind;
        logic [7:0]   version;
        logic [7:0]   msg_type;
        logic [7:0]   ttl;
        logic [63:0]  timestamp;
        logic         dest_present;
        logic [15:0]  payload_length;
        logic [63:0]  src_addr;
        logic [63:0]  dest_addr;
        logic [7:0]   payload_byte;
        logic         status;
        logic         last_result;
    } rec_t;

    // records produced by one byte transfer, header or payload first
    typedef struct packed {
        logic data_v;
        logic stat_v;
        rec_t data_rec;
        rec_t stat_rec;
    } push_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mesh_packet_stream_parser.sv -----
// top level of the mesh packet stream parser
// records of a byte are registered in the output queue before being offered
// throughput: one byte per cycle while record_ready is high and each byte
// yields at most one record; a byte that yields two (header or payload plus
// status) drops byte_ready until under two records sit in the 3-slot queue
// reset: asynchronous, clears the byte counter, header fields and queue count
`default_nettype none

module mesh_packet_stream_parser
    import mpsp_pkg::*;
#(
    parameter int MAX_PAYLOAD = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output logic             byte_ready,
    input  wire logic [7:0]  byte_value,
    input  wire logic        last_byte,
    output logic             record_valid,
    input  wire logic        record_ready,
    output logic [1:0]       record_kind,
    output logic [7:0]       version,
    output logic [7:0]       msg_type,
    output logic [7:0]       ttl,
    output logic [63:0]      timestamp,
    output logic             dest_present,
    output logic [15:0]      payload_length,
    output logic [63:0]      src_addr,
    output logic [63:0]      dest_addr,
    output logic [7:0]       payload_byte,
    output logic             status,
    output logic             last_result
);

    push_t push;
    rec_t  head;
    logic  take;

    assign take = byte_valid && byte_ready;

    // field parser
    mpsp_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .byte_value (byte_value),
        .last_byte  (last_byte),
        .push       (push)
    );

    // result queue
    mpsp_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .space      (byte_ready),
        .head_valid (record_valid),
        .head_ready (record_ready),
        .head       (head)
    );

    // output fields
    assign record_kind    = head.kind;
    assign version        = head.version;
    assign msg_type       = head.msg_type;
    assign ttl            = head.ttl;
    assign timestamp      = head.timestamp;
    assign dest_present   = head.dest_present;
    assign payload_length = head.payload_length;
    assign src_addr       = head.src_addr;
    assign dest_addr      = head.dest_addr;
    assign payload_byte   = head.payload_byte;
    assign status         = head.status;
    assign last_result    = head.last_result;

endmodule

`default_nettype wire

// ----- hw/rtl/mpsp_parser.sv -----
// packet field parser: header registers, byte counter and record generation
`default_nettype none

module mpsp_parser
    import mpsp_pkg::*;
#(
    parameter int MAX_PAYLOAD = 256
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       take,
    input  wire logic [7:0] byte_value,
    input  wire logic       last_byte,
    output push_t           push
);

    localparam logic [POS_W-1:0] CAP = POS_W'(MAX_PAYLOAD);

    logic [POS_W-1:0] pos_reg;
    logic [7:0]       version_reg;
    logic [7:0]       type_reg;
    logic [7:0]       ttl_reg;
    logic [63:0]      timestamp_reg;
    logic             flag_reg;
    logic [15:0]      length_reg;
    logic [63:0]      sender_reg;
    logic [63:0]      recipient_reg;

    logic [POS_W-1:0] pos_next;
    logic [7:0]       version_next;
    logic [7:0]       type_next;
    logic [7:0]       ttl_next;
    logic [63:0]      timestamp_next;
    logic             flag_next;
    logic [15:0]      length_next;
    logic [63:0]      sender_next;
    logic [63:0]      recipient_next;

    logic [POS_W-1:0] hdr_len;
    logic [POS_W:0]   pos_plus1;
    logic [POS_W:0]   need;
    logic [POS_W-1:0] lim;
    logic [POS_W-1:0] pay_index;
    logic             in_body;
    logic             hdr_done;
    logic             pay_hit;

    // field capture for the byte at the current position
    always_comb
    begin
        version_next   = version_reg;
        type_next      = type_reg;
        ttl_next       = ttl_reg;
        timestamp_next = timestamp_reg;
        flag_next      = flag_reg;
        length_next    = length_reg;
        sender_next    = sender_reg;
        recipient_next = recipient_reg;
        if (pos_reg == POS_VERSION)
        begin
            version_next = byte_value;
        end
        else if (pos_reg == POS_TYPE)
        begin
            type_next = byte_value;
        end
        else if (pos_reg == POS_TTL)
        begin
            ttl_next = byte_value;
        end
        else if (pos_reg <= POS_TS_LAST)
        begin
            timestamp_next = {timestamp_reg[55:0], byte_value};
        end
        else if (pos_reg == POS_FLAGS)
        begin
            flag_next = byte_value[FLAG_RECIPIENT_BIT];
        end
        else if (pos_reg <= POS_LEN_LAST)
        begin
            length_next = {length_reg[7:0], byte_value};
        end
        else if (pos_reg < HDR_LEN_SHORT)
        begin
            sender_next = {sender_reg[55:0], byte_value};
        end
        else if (flag_reg && pos_reg < HDR_LEN_LONG)
        begin
            recipient_next = {recipient_reg[55:0], byte_value};
        end
    end

    // header end, payload window and length check
    always_comb
    begin
        hdr_len   = flag_next ? HDR_LEN_LONG : HDR_LEN_SHORT;
        pos_plus1 = {1'b0, pos_reg} + (POS_W+1)'(1);
        need      = {1'b0, hdr_len} + (POS_W+1)'(length_next);
        lim       = ({1'b0, length_next} < CAP) ? {1'b0, length_next} : CAP;
        pay_index = pos_reg - hdr_len;
        in_body   = (pos_reg >= FIXED_PART);
        hdr_done  = in_body && (pos_plus1 == {1'b0, hdr_len});
        pay_hit   = in_body && !hdr_done && (pos_reg >= hdr_len) && (pay_index < lim);
        pos_next  = (pos_reg == POS_MAX) ? pos_reg : pos_plus1[POS_W-1:0];
    end

    // record assembly
    always_comb
    begin
        push = '0;
        push.data_v = take && (hdr_done || pay_hit);
        push.stat_v = take && last_byte;
        if (hdr_done)
        begin
            push.data_rec.kind           = KIND_HEADER;
            push.data_rec.version        = version_next;
            push.data_rec.msg_type       = type_next;
            push.data_rec.ttl            = ttl_next;
            push.data_rec.timestamp      = timestamp_next;
            push.data_rec.dest_present   = flag_next;
            push.data_rec.payload_length = length_next;
            push.data_rec.src_addr       = sender_next;
            push.data_rec.dest_addr      = recipient_next;
        end
        else
        begin
            push.data_rec.kind         = KIND_PAYLOAD;
            push.data_rec.payload_byte = byte_value;
        end
        push.stat_rec.kind        = KIND_STATUS;
        push.stat_rec.status      = (pos_plus1 < need) ? STATUS_TOO_SHORT : STATUS_OK;
        push.stat_rec.last_result = 1'b1;
    end

    // parser state, cleared after the last byte of a packet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            version_reg   <= '0;
            type_reg      <= '0;
            ttl_reg       <= '0;
            timestamp_reg <= '0;
            flag_reg      <= 1'b0;
            length_reg    <= '0;
            sender_reg    <= '0;
            recipient_reg <= '0;
        end
        else if (take)
        begin
            if (last_byte)
            begin
                pos_reg       <= '0;
                version_reg   <= '0;
                type_reg      <= '0;
                ttl_reg       <= '0;
                timestamp_reg <= '0;
                flag_reg      <= 1'b0;
                length_reg    <= '0;
                sender_reg    <= '0;
                recipient_reg <= '0;
            end
            else
            begin
                pos_reg       <= pos_next;
                version_reg   <= version_next;
                type_reg      <= type_next;
                ttl_reg       <= ttl_next;
                timestamp_reg <= timestamp_next;
                flag_reg      <= flag_next;
                length_reg    <= length_next;
                sender_reg    <= sender_next;
                recipient_reg <= recipient_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mpsp_out_queue.sv -----
// three-slot result queue taking up to two records per cycle
`default_nettype none

module mpsp_out_queue
    import mpsp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire push_t push,
    output logic       space,
    output logic       head_valid,
    input  wire logic  head_ready,
    output rec_t       head
);

    localparam int DEPTH = 3;

    rec_t       slot_reg [DEPTH];
    rec_t       slot_next [DEPTH];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic [1:0] cnt;
    logic       pop;
    logic       push_a;
    logic       push_b;
    rec_t       rec_a;

    assign head_valid = (count_reg != 2'd0);
    assign head       = slot_reg[0];
    assign space      = (count_reg < 2'd2);
    assign pop        = head_valid && head_ready;

    // compact the pushed records, data record ahead of status
    assign push_a = push.data_v || push.stat_v;
    assign push_b = push.data_v && push.stat_v;
    assign rec_a  = push.data_v ? push.data_rec : push.stat_rec;

    // shift out on transfer, then append new records
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_next[i] = slot_reg[i];
        end
        cnt = count_reg;
        if (pop)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                slot_next[i] = slot_reg[i+1];
            end
            cnt = count_reg - 2'd1;
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            if (push_a && cnt == 2'(i))
            begin
                slot_next[i] = rec_a;
            end
            if (push_b && 2'(cnt + 2'd1) == 2'(i))
            begin
                slot_next[i] = push.stat_rec;
            end
        end
        count_next = cnt + {1'b0, push_a} + {1'b0, push_b};
    end

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // record slots
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mpsp_checker.sv -----
// port-level checker for the mesh packet stream parser and its bind
`default_nettype none

module mpsp_checker
    import mpsp_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        record_valid,
    input wire logic        record_ready,
    input wire logic [1:0]  record_kind,
    input wire logic        dest_present,
    input wire logic [63:0] dest_addr,
    input wire logic        last_result
);

    // a stalled record stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        record_valid && !record_ready |=> record_valid)
        else $error("record valid dropped while stalled");

    // a stalled record keeps its kind and end mark
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        record_valid && !record_ready |=> $stable(record_kind) && $stable(last_result))
        else $error("record changed while stalled");

    // only the status record ends a packet
    a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        record_valid |-> (last_result == (record_kind == KIND_STATUS)))
        else $error("end mark on a non-status record");

    // without the recipient flag the recipient id is zero
    a_no_recipient: assert property (@(posedge clk) disable iff (!rst_n)
        record_valid && record_kind == KIND_HEADER && !dest_present
        |-> dest_addr == 64'd0)
        else $error("recipient id set without recipient flag");

endmodule

bind mesh_packet_stream_parser mpsp_checker u_mpsp_checker (.*);

`default_nettype wire
